/* rtl/dsp_pkg.sv */
// Shared types and constants for the shortest-path engine.
package dsp_pkg;

  localparam int DIST_BITS = 22;
  localparam int PRED_BITS = 7;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;
  localparam logic [PRED_BITS-1:0] PRED_NONE = 7'h7F;

  localparam logic OP_SET_LINK = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK2,
    ST_INIT,
    ST_RELAX,
    ST_WAIT,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  // One entry of the per-node search state.
  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [PRED_BITS-1:0] pred;
    logic visited;
    logic reached;
  } node_entry_t;

  // Tag that travels with each node read of a relaxation pass.
  typedef struct packed {
    logic valid;
    logic is_pick;
    logic first;
    logic last;
  } relax_ctl_t;

  // Outcome of one relaxation pass: the next node to settle, if any.
  typedef struct packed {
    logic done;
    logic found;
    logic [DIST_BITS-1:0] distance;
  } relax_res_t;

endpackage

/* rtl/dsp_ram.sv */
// Simple dual-port synchronous memory with a registered read.
module dsp_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/dsp_relax.sv */
// Relaxation datapath: updates one node per cycle and tracks the next node to settle.
module dsp_relax #(
  parameter int NB = 6,
  parameter int WB = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dsp_pkg::relax_ctl_t              ctl_in,
  input  logic [NB-1:0]                    idx_in,
  input  logic [NB-1:0]                    pick,
  input  logic [dsp_pkg::DIST_BITS-1:0]    pick_dist,
  input  dsp_pkg::node_entry_t             node_rd,
  input  logic [WB:0]                      link_rd,
  output logic                             node_we,
  output logic [NB-1:0]                    node_waddr,
  output dsp_pkg::node_entry_t             node_wdata,
  output dsp_pkg::relax_res_t              res,
  output logic [NB-1:0]                    res_idx
);

  import dsp_pkg::*;

  localparam int SUM_W = ((WB > DIST_BITS) ? WB : DIST_BITS) + 1;

  relax_ctl_t           s1_ctl_r;
  logic [NB-1:0]        s1_idx_r;
  relax_ctl_t           s2_ctl_r;
  logic [NB-1:0]        s2_idx_r;
  node_entry_t          s2_entry_r;
  logic                 trk_found_r;
  logic [NB-1:0]        trk_idx_r;
  logic [DIST_BITS-1:0] trk_dist_r;
  logic                 res_done_r;
  logic                 res_found_r;
  logic [DIST_BITS-1:0] res_dist_r;
  logic [NB-1:0]        res_idx_r;

  logic [SUM_W-1:0]     sum;
  logic [DIST_BITS-1:0] sum_sat;
  node_entry_t          upd;
  logic                 cand;
  logic                 base_found;
  logic                 take;
  logic                 trk_found_nxt;
  logic [NB-1:0]        trk_idx_nxt;
  logic [DIST_BITS-1:0] trk_dist_nxt;

  // First stage: the read data of node and link memories are here.
  always_comb begin
    sum = SUM_W'(pick_dist) + SUM_W'(link_rd[WB-1:0]);
    if (sum > SUM_W'(DIST_MAX)) begin
      sum_sat = DIST_MAX;
    end else begin
      sum_sat = DIST_BITS'(sum);
    end
    upd = node_rd;
    if (s1_ctl_r.is_pick) begin
      upd.visited = 1'b1;
    end else if (!node_rd.visited && link_rd[WB] &&
                 (!node_rd.reached || sum_sat < node_rd.distance)) begin
      upd.distance = sum_sat;
      upd.pred     = PRED_BITS'(pick);
      upd.reached  = 1'b1;
    end
  end

  assign node_we    = s1_ctl_r.valid;
  assign node_waddr = s1_idx_r;
  assign node_wdata = upd;

  // Second stage: the lowest-index minimum over unvisited reached nodes.
  always_comb begin
    cand          = s2_ctl_r.valid && s2_entry_r.reached && !s2_entry_r.visited;
    base_found    = s2_ctl_r.first ? 1'b0 : trk_found_r;
    take          = cand && (!base_found || s2_entry_r.distance < trk_dist_r);
    trk_found_nxt = base_found | take;
    trk_idx_nxt   = take ? s2_idx_r : trk_idx_r;
    trk_dist_nxt  = take ? s2_entry_r.distance : trk_dist_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r   <= '0;
      s2_ctl_r   <= '0;
      res_done_r <= 1'b0;
    end else begin
      s1_ctl_r   <= ctl_in;
      s2_ctl_r   <= s1_ctl_r.valid ? s1_ctl_r : '0;
      res_done_r <= s2_ctl_r.valid && s2_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= idx_in;
    s2_idx_r   <= s1_idx_r;
    s2_entry_r <= upd;
    if (s2_ctl_r.valid) begin
      trk_found_r <= trk_found_nxt;
      trk_idx_r   <= trk_idx_nxt;
      trk_dist_r  <= trk_dist_nxt;
      res_found_r <= trk_found_nxt;
      res_dist_r  <= trk_dist_nxt;
      res_idx_r   <= trk_idx_nxt;
    end
  end

  assign res     = {res_done_r, res_found_r, res_dist_r};
  assign res_idx = res_idx_r;

endmodule

/* rtl/dijkstra_shortest_path.sv */
// Shortest-path engine: Dijkstra's algorithm over a stored symmetric link-weight matrix.
// A set-link item writes the weight at (a, b) and then at (b, a). A route item with n active
// nodes initialises the node state, runs up to n relaxation rounds, then emits n results,
// one a cycle. After reset the link memory is cleared one entry a cycle; busy stays high
// meanwhile. Results cannot be stalled.
module dijkstra_shortest_path #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic [6:0]                            cfg_node_count,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_operation,
  input  logic [5:0]                            in_node_a,
  input  logic [5:0]                            in_node_b,
  input  logic signed [16:0]                    in_weight,
  input  logic [5:0]                            in_source_node,
  output logic                                  out_valid,
  output logic [5:0]                            out_node_index,
  output logic [dsp_pkg::DIST_BITS-1:0]         out_distance,
  output logic signed [dsp_pkg::PRED_BITS-1:0]  out_predecessor,
  output logic                                  out_reachable,
  output logic                                  out_last
);

  import dsp_pkg::*;

  localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LAW = 2 * NB;
  localparam int LDW = WEIGHT_BITS + 1;

  state_t         state_r, state_nxt;
  logic [6:0]     cfg_node_count_r;
  logic [NB-1:0]  idx_r, idx_nxt;
  logic [NB-1:0]  nm1_r, nm1_nxt;
  logic [NB-1:0]  src_r, src_nxt;
  logic           src_ok_r, src_ok_nxt;
  logic [NB-1:0]  pick_r, pick_nxt;
  logic [DIST_BITS-1:0] pick_dist_r, pick_dist_nxt;
  logic [LAW-1:0] clr_r, clr_nxt;
  logic [LAW-1:0] lnk2_addr_r, lnk2_addr_nxt;
  logic [LDW-1:0] lnk2_data_r, lnk2_data_nxt;

  logic           link_we;
  logic [LAW-1:0] link_waddr;
  logic [LDW-1:0] link_wdata;
  logic [LDW-1:0] link_rd;
  logic [LDW-1:0] new_link;
  logic [NB-1:0]  route_nm1;
  logic           in_range;

  logic           init_we;
  node_entry_t    init_entry;
  logic           node_we;
  logic [NB-1:0]  node_waddr;
  node_entry_t    node_wdata;
  node_entry_t    node_rd;

  relax_ctl_t     relax_ctl;
  logic           rlx_we;
  logic [NB-1:0]  rlx_waddr;
  node_entry_t    rlx_wdata;
  relax_res_t     rlx_res;
  logic [NB-1:0]  rlx_res_idx;

  logic           em_issue;
  logic           em_v_r;
  logic           em_last_r;
  logic [NB-1:0]  em_idx_r;
  logic           out_valid_r;
  logic [5:0]     out_node_index_r;
  logic [DIST_BITS-1:0] out_distance_r;
  logic [PRED_BITS-1:0] out_predecessor_r;
  logic           out_reachable_r;
  logic           out_last_r;

  // Weight as stored: a valid bit over the saturated magnitude.
  always_comb begin
    if (in_weight[16]) begin
      new_link = '0;
    end else if ((in_weight[15:0] >> WEIGHT_BITS) != 16'd0) begin
      new_link = {1'b1, {WEIGHT_BITS{1'b1}}};
    end else begin
      new_link = {1'b1, WEIGHT_BITS'(in_weight[15:0])};
    end
    in_range = (32'(in_node_a) < MAX_NODES) && (32'(in_node_b) < MAX_NODES);
    if (cfg_node_count_r == 7'd0) begin
      route_nm1 = '0;
    end else if (32'(cfg_node_count_r) > MAX_NODES) begin
      route_nm1 = NB'(MAX_NODES - 1);
    end else begin
      route_nm1 = NB'(cfg_node_count_r - 7'd1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    nm1_nxt       = nm1_r;
    src_nxt       = src_r;
    src_ok_nxt    = src_ok_r;
    pick_nxt      = pick_r;
    pick_dist_nxt = pick_dist_r;
    clr_nxt       = clr_r;
    lnk2_addr_nxt = lnk2_addr_r;
    lnk2_data_nxt = lnk2_data_r;
    busy          = 1'b1;
    link_we       = 1'b0;
    link_waddr    = clr_r;
    link_wdata    = '0;
    init_we       = 1'b0;
    init_entry.distance = DIST_MAX;
    init_entry.pred     = PRED_NONE;
    init_entry.visited  = 1'b0;
    init_entry.reached  = 1'b0;
    relax_ctl     = '0;
    em_issue      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        link_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {LAW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_operation == OP_SET_LINK) begin
            if (in_range) begin
              link_we       = 1'b1;
              link_waddr    = {NB'(in_node_a), NB'(in_node_b)};
              link_wdata    = new_link;
              lnk2_addr_nxt = {NB'(in_node_b), NB'(in_node_a)};
              lnk2_data_nxt = new_link;
              state_nxt     = ST_LINK2;
            end
          end else begin
            nm1_nxt    = route_nm1;
            src_nxt    = NB'(in_source_node);
            src_ok_nxt = 32'(in_source_node) <= 32'(route_nm1);
            idx_nxt    = '0;
            state_nxt  = ST_INIT;
          end
        end
      end
      ST_LINK2: begin
        link_we    = 1'b1;
        link_waddr = lnk2_addr_r;
        link_wdata = lnk2_data_r;
        state_nxt  = ST_IDLE;
      end
      ST_INIT: begin
        init_we = 1'b1;
        if (src_ok_r && idx_r == src_r) begin
          init_entry.distance = '0;
          init_entry.reached  = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == nm1_r) begin
          idx_nxt = '0;
          if (src_ok_r) begin
            pick_nxt      = src_r;
            pick_dist_nxt = '0;
            state_nxt     = ST_RELAX;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_RELAX: begin
        relax_ctl.valid   = 1'b1;
        relax_ctl.is_pick = (idx_r == pick_r);
        relax_ctl.first   = (idx_r == '0);
        relax_ctl.last    = (idx_r == nm1_r);
        idx_nxt = idx_r + 1'b1;
        if (idx_r == nm1_r) begin
          idx_nxt   = '0;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rlx_res.done) begin
          if (rlx_res.found) begin
            pick_nxt      = rlx_res_idx;
            pick_dist_nxt = rlx_res.distance;
            state_nxt     = ST_RELAX;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        em_issue = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == nm1_r) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      clr_r            <= '0;
      cfg_node_count_r <= 7'd64;
      em_v_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      em_v_r      <= em_issue;
      out_valid_r <= em_v_r;
      if (cfg_write_en) begin
        cfg_node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    nm1_r       <= nm1_nxt;
    src_r       <= src_nxt;
    src_ok_r    <= src_ok_nxt;
    pick_r      <= pick_nxt;
    pick_dist_r <= pick_dist_nxt;
    lnk2_addr_r <= lnk2_addr_nxt;
    lnk2_data_r <= lnk2_data_nxt;
    em_idx_r    <= idx_r;
    em_last_r   <= (idx_r == nm1_r);
    if (em_v_r) begin
      out_node_index_r <= 6'(em_idx_r);
      out_last_r       <= em_last_r;
      out_reachable_r  <= node_rd.reached;
      out_distance_r   <= node_rd.reached ? node_rd.distance : '0;
      out_predecessor_r <= node_rd.reached ? node_rd.pred : PRED_NONE;
    end
  end

  assign node_we    = init_we | rlx_we;
  assign node_waddr = init_we ? idx_r : rlx_waddr;
  assign node_wdata = init_we ? init_entry : rlx_wdata;

  dsp_ram #(
    .AW (LAW),
    .DW (LDW)
  ) u_link_mem (
    .clk     (clk),
    .we      (link_we),
    .waddr   (link_waddr),
    .wdata   (link_wdata),
    .raddr   ({idx_r, pick_r}),
    .rdata_r (link_rd)
  );

  dsp_ram #(
    .AW (NB),
    .DW ($bits(node_entry_t))
  ) u_node_mem (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_waddr),
    .wdata   (node_wdata),
    .raddr   (idx_r),
    .rdata_r (node_rd)
  );

  dsp_relax #(
    .NB (NB),
    .WB (WEIGHT_BITS)
  ) u_relax (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (relax_ctl),
    .idx_in     (idx_r),
    .pick       (pick_r),
    .pick_dist  (pick_dist_r),
    .node_rd    (node_rd),
    .link_rd    (link_rd),
    .node_we    (rlx_we),
    .node_waddr (rlx_waddr),
    .node_wdata (rlx_wdata),
    .res        (rlx_res),
    .res_idx    (rlx_res_idx)
  );

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_node_index_r;
  assign out_distance    = out_distance_r;
  assign out_predecessor = out_predecessor_r;
  assign out_reachable   = out_reachable_r;
  assign out_last        = out_last_r;

endmodule
